/* rtl/core/ipr_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the image packet reassembler
// no dependencies

package ipr_pkg;

  // default configuration of the block
  localparam int MAX_IMAGE_BYTES_DEF = 65536;
  localparam int PAYLOAD_BYTES_DEF   = 240;
  localparam int MAX_PACKETS_DEF     = 512;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  // start-of-image marker expected in the first two bytes
  localparam logic [7:0] SOI_BYTE0 = 8'hFF;
  localparam logic [7:0] SOI_BYTE1 = 8'hD8;

  // commands
  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // result status codes
  localparam logic [3:0] ST_TAKEN    = 4'd0;
  localparam logic [3:0] ST_DROPPED  = 4'd1;
  localparam logic [3:0] ST_DUP      = 4'd2;
  localparam logic [3:0] ST_PKT_DONE = 4'd3;
  localparam logic [3:0] ST_COMPLETE = 4'd4;
  localparam logic [3:0] ST_BAD_MARK = 4'd5;
  localparam logic [3:0] ST_TIMEOUT  = 4'd6;
  localparam logic [3:0] ST_HDR_OK   = 4'd7;
  localparam logic [3:0] ST_HDR_REJ  = 4'd8;
  localparam logic [3:0] ST_OTHER    = 4'd9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [20:0] image_bytes;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  resolution_mode;
    logic [15:0] packet_number;
    logic [7:0]  packet_length;
    logic [7:0]  byte_offset;
    logic [7:0]  data_byte;
    logic        packet_end;
    logic [15:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  read_data;
    logic [9:0]  packets_received;
    logic [9:0]  packets_expected;
    logic        receiving;
    logic [31:0] images_complete;
    logic [31:0] images_lost;
    logic [15:0] done_width;
    logic [15:0] done_height;
    logic [7:0]  done_mode;
    logic [16:0] done_bytes;
  } out_item_t;

endpackage

/* rtl/core/image_packet_reassembler.sv */
`timescale 1ns / 1ps
// image packet reassembler top level: frame store, received-packet map, control
// depends on ipr_pkg

// Rebuilds one image from numbered packets delivered one payload byte per
// transfer, and answers every input transfer with exactly one result. An item
// is first accepted, which launches the reads of the frame store and the
// received-packet map; in S_EXEC the block then decides on the read data,
// writes both memories back and loads the output register. After an accepted
// header a sweep in S_CLEAR clears the received-packet map one entry per cycle
// and counts the packets of the new image as it goes, then S_DONE
// loads its result; no input is taken during the sweep. While the previous
// result is held by out_stall the item in flight waits, and so does the input.
// The frame store holds MAX_IMAGE_BYTES bytes and starts undefined; only bytes
// that were written may be read back. The user must write the timeout register
// via the cfg_ port only while no item is in flight; the block does not check.

module image_packet_reassembler #(
  parameter int MAX_IMAGE_BYTES = ipr_pkg::MAX_IMAGE_BYTES_DEF,
  parameter int PAYLOAD_BYTES   = ipr_pkg::PAYLOAD_BYTES_DEF,
  parameter int MAX_PACKETS     = ipr_pkg::MAX_PACKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ipr_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ipr_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  localparam int ADDR_W = $clog2(MAX_IMAGE_BYTES);
  localparam int IDX_W  = $clog2(MAX_PACKETS);
  localparam int CNT_W  = $clog2(MAX_PACKETS + 1);
  localparam int EB_W   = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int POS_W  = $clog2(MAX_PACKETS * PAYLOAD_BYTES + 256);
  localparam int CMP_W  = (POS_W > 22) ? POS_W : 22;
  localparam int NCW    = (CNT_W > 16) ? CNT_W : 16;

  // memories
  logic [7:0] frame_mem [MAX_IMAGE_BYTES];
  logic       map_mem   [MAX_PACKETS];

  ipr_pkg::state_t state_r, state_nxt;

  ipr_pkg::in_item_t item_r;
  logic [POS_W-1:0]  pos_r;
  logic              map_rd_r;
  logic [7:0]        frame_rd_r;
  logic              rd_ok_r;

  logic [CNT_W-1:0]  clr_cnt_r;
  logic [POS_W-1:0]  acc_r;
  logic [CNT_W-1:0]  pkts_r;

  logic [EB_W-1:0]   exp_bytes_r, exp_bytes_nxt;
  logic [CNT_W-1:0]  exp_pkts_r, exp_pkts_nxt;
  logic [CNT_W-1:0]  acc_pkts_r, acc_pkts_nxt;
  logic              active_r, active_nxt;
  logic [15:0]       idle_r, idle_nxt;
  logic [7:0]        fb0_r, fb0_nxt;
  logic [7:0]        fb1_r, fb1_nxt;
  logic [15:0]       width_r, width_nxt;
  logic [15:0]       height_r, height_nxt;
  logic [7:0]        mode_r, mode_nxt;
  logic [EB_W-1:0]   hdr_bytes_r, hdr_bytes_nxt;
  logic [31:0]       good_r, good_nxt;
  logic [31:0]       lost_r, lost_nxt;
  logic [15:0]       timeout_r;

  logic              out_valid_r;
  ipr_pkg::out_item_t out_r, out_nxt;

  logic              in_acc;
  logic              out_free;
  logic              hdr_ok;
  logic              hdr_cmd;
  logic              clr_last;
  logic              commit;
  logic              frame_we;
  logic              byte_mark;
  logic [3:0]        status_nxt;
  logic [7:0]        rdata_nxt;
  logic              byte_stored;
  logic [POS_W-1:0]  pos_in;
  logic [CMP_W-1:0]  rd_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic              map_we;
  logic [IDX_W-1:0]  map_wa;
  logic              map_wd;

  // ---------------------------------------------------------------------------
  // handshake and control outputs
  always_comb begin
    in_stall  = (state_r != ipr_pkg::S_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
    cfg_ready = 1'b1;
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign hdr_cmd  = (item_r.command == ipr_pkg::CMD_HEADER);
  assign hdr_ok   = (item_r.image_bytes != 21'd0) &&
                    (CMP_W'(item_r.image_bytes) <= CMP_W'(MAX_IMAGE_BYTES)) &&
                    (CMP_W'(item_r.image_bytes) <= CMP_W'(MAX_PACKETS * PAYLOAD_BYTES));
  assign clr_last = (clr_cnt_r == CNT_W'(MAX_PACKETS - 1));
  assign commit   = out_free &&
                    (((state_r == ipr_pkg::S_EXEC) && !(hdr_cmd && hdr_ok)) ||
                     (state_r == ipr_pkg::S_DONE));

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipr_pkg::S_IDLE: begin
        if (in_acc) state_nxt = ipr_pkg::S_EXEC;
      end
      ipr_pkg::S_EXEC: begin
        if (hdr_cmd && hdr_ok) state_nxt = ipr_pkg::S_CLEAR;
        else if (out_free)     state_nxt = ipr_pkg::S_IDLE;
      end
      ipr_pkg::S_CLEAR: begin
        if (clr_last) state_nxt = ipr_pkg::S_DONE;
      end
      ipr_pkg::S_DONE: begin
        if (out_free) state_nxt = ipr_pkg::S_IDLE;
      end
      default: state_nxt = ipr_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // item capture and memory reads
  assign pos_in = POS_W'(in_data.packet_number[IDX_W-1:0]) * POS_W'(PAYLOAD_BYTES) +
                  POS_W'(in_data.byte_offset);
  assign rd_ext = CMP_W'(in_data.read_address);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r   <= in_data;
      pos_r    <= pos_in;
      map_rd_r <= map_mem[in_data.packet_number[IDX_W-1:0]];
      rd_ok_r  <= (rd_ext < CMP_W'(MAX_IMAGE_BYTES));
      if ((in_data.command == ipr_pkg::CMD_READ) && (rd_ext < CMP_W'(MAX_IMAGE_BYTES))) begin
        frame_rd_r <= frame_mem[rd_ext[ADDR_W-1:0]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // memory writes
  assign pos_ext = CMP_W'(pos_r);

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[pos_ext[ADDR_W-1:0]] <= item_r.data_byte;
    end
  end

  always_comb begin
    if (state_r == ipr_pkg::S_CLEAR) begin
      map_we = 1'b1;
      map_wa = clr_cnt_r[IDX_W-1:0];
      map_wd = 1'b0;
    end else begin
      map_we = byte_mark;
      map_wa = item_r.packet_number[IDX_W-1:0];
      map_wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
  end

  // ---------------------------------------------------------------------------
  // map clearing sweep, counting packets of the new image on the way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      acc_r     <= '0;
      pkts_r    <= '0;
    end else if (state_r == ipr_pkg::S_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      acc_r     <= acc_r + POS_W'(PAYLOAD_BYTES);
      if (CMP_W'(acc_r) < CMP_W'(item_r.image_bytes)) begin
        pkts_r <= pkts_r + CNT_W'(1);
      end
    end else if (state_r == ipr_pkg::S_EXEC) begin
      clr_cnt_r <= '0;
      acc_r     <= '0;
      pkts_r    <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // item update
  always_comb begin
    exp_bytes_nxt = exp_bytes_r;
    exp_pkts_nxt  = exp_pkts_r;
    acc_pkts_nxt  = acc_pkts_r;
    active_nxt    = active_r;
    idle_nxt      = idle_r;
    fb0_nxt       = fb0_r;
    fb1_nxt       = fb1_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    mode_nxt      = mode_r;
    hdr_bytes_nxt = hdr_bytes_r;
    good_nxt      = good_r;
    lost_nxt      = lost_r;
    status_nxt    = ipr_pkg::ST_OTHER;
    rdata_nxt     = 8'd0;
    byte_stored   = 1'b0;
    frame_we      = 1'b0;
    byte_mark     = 1'b0;

    case (item_r.command)
      ipr_pkg::CMD_HEADER: begin
        exp_bytes_nxt = '0;
        exp_pkts_nxt  = '0;
        acc_pkts_nxt  = '0;
        active_nxt    = 1'b0;
        if (hdr_ok) begin
          exp_bytes_nxt = EB_W'(item_r.image_bytes);
          exp_pkts_nxt  = pkts_r;
          hdr_bytes_nxt = EB_W'(item_r.image_bytes);
          width_nxt     = item_r.image_width;
          height_nxt    = item_r.image_height;
          mode_nxt      = item_r.resolution_mode;
          fb0_nxt       = 8'd0;
          fb1_nxt       = 8'd0;
          idle_nxt      = 16'd0;
          active_nxt    = 1'b1;
          status_nxt    = ipr_pkg::ST_HDR_OK;
        end else begin
          status_nxt = ipr_pkg::ST_HDR_REJ;
        end
      end
      ipr_pkg::CMD_BYTE: begin
        if (!active_r ||
            (NCW'(item_r.packet_number) >= NCW'(exp_pkts_r)) ||
            (NCW'(item_r.packet_number) >= NCW'(MAX_PACKETS))) begin
          status_nxt = ipr_pkg::ST_DROPPED;
        end else if (map_rd_r) begin
          status_nxt = ipr_pkg::ST_DUP;
        end else begin
          byte_stored = (item_r.byte_offset < item_r.packet_length) &&
                        (CMP_W'(item_r.byte_offset) < CMP_W'(PAYLOAD_BYTES)) &&
                        (pos_ext < CMP_W'(exp_bytes_r)) &&
                        (pos_ext < CMP_W'(MAX_IMAGE_BYTES));
          frame_we = commit && byte_stored;
          if (byte_stored && (pos_ext == CMP_W'(0))) fb0_nxt = item_r.data_byte;
          if (byte_stored && (pos_ext == CMP_W'(1))) fb1_nxt = item_r.data_byte;
          if (!item_r.packet_end) begin
            status_nxt = byte_stored ? ipr_pkg::ST_TAKEN : ipr_pkg::ST_DROPPED;
          end else begin
            byte_mark    = commit;
            acc_pkts_nxt = acc_pkts_r + CNT_W'(1);
            idle_nxt     = 16'd0;
            if (acc_pkts_nxt < exp_pkts_r) begin
              status_nxt = ipr_pkg::ST_PKT_DONE;
            end else begin
              exp_bytes_nxt = '0;
              exp_pkts_nxt  = '0;
              acc_pkts_nxt  = '0;
              active_nxt    = 1'b0;
              // image is good only with the start-of-image marker in place
              if ((fb0_nxt == ipr_pkg::SOI_BYTE0) && (fb1_nxt == ipr_pkg::SOI_BYTE1)) begin
                good_nxt   = good_r + 32'd1;
                status_nxt = ipr_pkg::ST_COMPLETE;
              end else begin
                lost_nxt   = lost_r + 32'd1;
                status_nxt = ipr_pkg::ST_BAD_MARK;
              end
            end
          end
        end
      end
      ipr_pkg::CMD_TICK: begin
        if (active_r) begin
          if (idle_r >= timeout_r) begin
            lost_nxt      = lost_r + 32'd1;
            exp_bytes_nxt = '0;
            exp_pkts_nxt  = '0;
            acc_pkts_nxt  = '0;
            active_nxt    = 1'b0;
            status_nxt    = ipr_pkg::ST_TIMEOUT;
          end else begin
            idle_nxt = idle_r + 16'd1;
          end
        end
      end
      ipr_pkg::CMD_READ: begin
        rdata_nxt = rd_ok_r ? frame_rd_r : 8'd0;
      end
      default: begin
        rdata_nxt = 8'd0;
      end
    endcase

    out_nxt.status           = status_nxt;
    out_nxt.read_data        = rdata_nxt;
    out_nxt.packets_received = 10'(acc_pkts_nxt);
    out_nxt.packets_expected = 10'(exp_pkts_nxt);
    out_nxt.receiving        = active_nxt;
    out_nxt.images_complete  = good_nxt;
    out_nxt.images_lost      = lost_nxt;
    out_nxt.done_width       = width_nxt;
    out_nxt.done_height      = height_nxt;
    out_nxt.done_mode        = mode_nxt;
    out_nxt.done_bytes       = 17'(hdr_bytes_nxt);
  end

  // ---------------------------------------------------------------------------
  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipr_pkg::S_IDLE;
      exp_bytes_r <= '0;
      exp_pkts_r  <= '0;
      acc_pkts_r  <= '0;
      active_r    <= 1'b0;
      idle_r      <= 16'd0;
      fb0_r       <= 8'd0;
      fb1_r       <= 8'd0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      mode_r      <= 8'd0;
      hdr_bytes_r <= '0;
      good_r      <= 32'd0;
      lost_r      <= 32'd0;
      timeout_r   <= ipr_pkg::TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      if (commit) begin
        exp_bytes_r <= exp_bytes_nxt;
        exp_pkts_r  <= exp_pkts_nxt;
        acc_pkts_r  <= acc_pkts_nxt;
        active_r    <= active_nxt;
        idle_r      <= idle_nxt;
        fb0_r       <= fb0_nxt;
        fb1_r       <= fb1_nxt;
        width_r     <= width_nxt;
        height_r    <= height_nxt;
        mode_r      <= mode_nxt;
        hdr_bytes_r <= hdr_bytes_nxt;
        good_r      <= good_nxt;
        lost_r      <= lost_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (commit) out_r <= out_nxt;
  end

endmodule

/* rtl/core/ipr_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the image packet reassembler, bound to the top level
// depends on ipr_pkg and image_packet_reassembler

module ipr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ipr_pkg::out_item_t out_data
);

  // an idle reassembler reports no packet counts
  a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.receiving) |->
      (out_data.packets_received == 10'd0) && (out_data.packets_expected == 10'd0))
    else $error("counts nonzero while not receiving");

  // an accepted header opens a reception
  a_hdr_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ipr_pkg::ST_HDR_OK)) |-> out_data.receiving)
    else $error("header accepted but not receiving");

  // completion, bad marker, timeout and a rejected header all close the reception
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.status == ipr_pkg::ST_COMPLETE) ||
                   (out_data.status == ipr_pkg::ST_BAD_MARK) ||
                   (out_data.status == ipr_pkg::ST_TIMEOUT) ||
                   (out_data.status == ipr_pkg::ST_HDR_REJ))) |-> !out_data.receiving)
    else $error("reception still open after it ended");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind image_packet_reassembler ipr_checker u_ipr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
